// ----- sv/ssba_pkg.sv -----
`timescale 1ns / 1ps

package ssba_pkg;

    localparam int CELL_BITS  = 32;
    localparam int CELL_W     = 5;
    localparam int SLOT_W     = 7;
    localparam int CELL_IDX_W = SLOT_W - CELL_W;
    localparam int WORD_W     = 32;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;
    localparam logic [1:0] REQ_BAD   = 2'd3;

    localparam logic [1:0] POOL_LARGE  = 2'd0;
    localparam logic [1:0] POOL_MEDIUM = 2'd1;
    localparam logic [1:0] POOL_SMALL  = 2'd2;
    localparam logic [1:0] POOL_BAD    = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_POOL = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [1:0]        pool;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] control_word;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] result_slot;
        logic              write_valid;
        logic [1:0]        write_pool;
        logic [WORD_W-1:0] write_data;
    } rsp_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        req_type;
        logic [1:0]        pool;
        logic [SLOT_W-1:0] slot;
        logic [WORD_W-1:0] word;
        logic [1:0]        status;
        logic              found;
    } tok_t;

    function automatic logic [CELL_BITS-1:0] cell_mask(input int size, input int idx);
        logic [CELL_BITS-1:0] m;
        m = '0;
        for (int i = 0; i < CELL_BITS; i++)
        begin
            m[i] = ((idx * CELL_BITS + i) < size);
        end
        return m;
    endfunction

endpackage

// ----- sv/sprite_slot_bitmap_allocator.sv -----
`timescale 1ns / 1ps

// Sprite control slot allocator for three pools (large, medium, small).
// A request transfer on the req channel allocates the lowest free slot of a
// pool, writes a control word to a named slot, or frees a slot. Each request
// gives exactly one transfer on the rsp channel with a status, the slot and
// the control register write to issue, if any.
// The used bits live in a chain of cells of 32 slots each, one cell per 32
// slots of the largest pool. A request walks the chain one cell per cycle
// through the entry register and the N cells, where N is the number of cells
// (4 with the default sizes), and its response is registered at the output.
// req_stall holds off the next request until the last one leaves the chain.
// While a response waits under rsp_stall, the next request is still taken;
// its response is parked in a hold register, and req_stall stays high until
// that hold register drains.
// Reset marks every slot free and empties the chain and the output.

module sprite_slot_bitmap_allocator #(
    parameter int LARGE_SLOTS  = 64,
    parameter int MEDIUM_SLOTS = 64,
    parameter int SMALL_SLOTS  = 128
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  ssba_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output ssba_pkg::rsp_t rsp
);

    localparam int CB        = ssba_pkg::CELL_BITS;
    localparam int SZ_W      = ssba_pkg::SLOT_W + 1;
    localparam int MAX_LM    = (LARGE_SLOTS > MEDIUM_SLOTS) ? LARGE_SLOTS : MEDIUM_SLOTS;
    localparam int MAX_SLOTS = (MAX_LM > SMALL_SLOTS) ? MAX_LM : SMALL_SLOTS;
    localparam int N_CELLS   = (MAX_SLOTS + CB - 1) / CB;

    localparam logic [SZ_W-1:0] LARGE_SIZE  = SZ_W'(LARGE_SLOTS);
    localparam logic [SZ_W-1:0] MEDIUM_SIZE = SZ_W'(MEDIUM_SLOTS);
    localparam logic [SZ_W-1:0] SMALL_SIZE  = SZ_W'(SMALL_SLOTS);

    ssba_pkg::tok_t chain [0:N_CELLS];
    ssba_pkg::tok_t tok0_reg, tok0_next;
    ssba_pkg::tok_t tok_end;

    logic            busy_reg, busy_next;
    logic            hold_valid_reg, hold_valid_next;
    ssba_pkg::rsp_t  hold_reg, hold_next;
    logic            rsp_valid_reg, rsp_valid_next;
    ssba_pkg::rsp_t  rsp_reg, rsp_next;

    logic            accept;
    logic            out_free;
    logic [SZ_W-1:0] pool_size;
    logic [1:0]      entry_status;
    ssba_pkg::rsp_t  end_rsp;
    logic [N_CELLS:0] chain_valid;

    assign accept   = req_valid && !req_stall;
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        unique case (req.pool)
            ssba_pkg::POOL_LARGE:  pool_size = LARGE_SIZE;
            ssba_pkg::POOL_MEDIUM: pool_size = MEDIUM_SIZE;
            ssba_pkg::POOL_SMALL:  pool_size = SMALL_SIZE;
            default:               pool_size = '0;
        endcase

        priority if (req.req_type == ssba_pkg::REQ_BAD || req.pool == ssba_pkg::POOL_BAD)
        begin
            entry_status = ssba_pkg::ST_BAD_POOL;
        end
        else if (req.req_type != ssba_pkg::REQ_ALLOC && {1'b0, req.slot} >= pool_size)
        begin
            entry_status = ssba_pkg::ST_RANGE;
        end
        else
        begin
            entry_status = ssba_pkg::ST_OK;
        end

        tok0_next.valid    = accept;
        tok0_next.req_type = req.req_type;
        tok0_next.pool     = req.pool;
        tok0_next.slot     = req.slot;
        tok0_next.word     = req.control_word;
        tok0_next.status   = entry_status;
        tok0_next.found    = 1'b0;
    end

    assign chain[0] = tok0_reg;

    for (genvar k = 0; k < N_CELLS; k++)
    begin : g_cell
        ssba_cell #(
            .CELL_IDX     (k),
            .LARGE_SLOTS  (LARGE_SLOTS),
            .MEDIUM_SLOTS (MEDIUM_SLOTS),
            .SMALL_SLOTS  (SMALL_SLOTS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (chain[k]),
            .tok_out (chain[k + 1])
        );
    end

    assign tok_end = chain[N_CELLS];

    always_comb
    begin
        for (int k = 0; k <= N_CELLS; k++)
        begin
            chain_valid[k] = chain[k].valid;
        end
    end

    always_comb
    begin
        end_rsp = '0;
        if (tok_end.status == ssba_pkg::ST_OK && tok_end.req_type == ssba_pkg::REQ_ALLOC
            && !tok_end.found)
        begin
            end_rsp.status = ssba_pkg::ST_FULL;
        end
        else
        begin
            end_rsp.status = tok_end.status;
        end

        if (end_rsp.status == ssba_pkg::ST_OK)
        begin
            end_rsp.result_slot = tok_end.slot;
            end_rsp.write_valid = 1'b1;
            end_rsp.write_pool  = tok_end.pool;
            end_rsp.write_data  = (tok_end.req_type == ssba_pkg::REQ_FREE) ? '0 : tok_end.word;
        end
    end

    always_comb
    begin
        busy_next       = busy_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_next        = rsp_reg;

        if (accept)
        begin
            busy_next = 1'b1;
        end

        priority if (tok_end.valid)
        begin
            busy_next = 1'b0;
            if (out_free)
            begin
                rsp_valid_next = 1'b1;
                rsp_next       = end_rsp;
            end
            else
            begin
                hold_valid_next = 1'b1;
                hold_next       = end_rsp;
            end
        end
        else if (hold_valid_reg && out_free)
        begin
            hold_valid_next = 1'b0;
            rsp_valid_next  = 1'b1;
            rsp_next        = hold_reg;
        end
        else if (out_free)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok0_reg       <= '0;
            busy_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            tok0_reg       <= tok0_next;
            busy_reg       <= busy_next;
            hold_valid_reg <= hold_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        rsp_reg  <= rsp_next;
    end

    assign req_stall = busy_reg || hold_valid_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(chain_valid) <= 1)
        else $error("More than one request is inside the cell chain.");

    a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (|chain_valid) |-> busy_reg)
        else $error("A request is in the cell chain while the block is not busy.");

    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> !busy_reg)
        else $error("A response is held while a request is still in the chain.");

    a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.write_valid) |-> (rsp_reg.status == ssba_pkg::ST_OK))
        else $error("A control register write is issued with an error status.");

endmodule

// ----- sv/ssba_cell.sv -----
`timescale 1ns / 1ps

module ssba_cell #(
    parameter int CELL_IDX     = 0,
    parameter int LARGE_SLOTS  = 64,
    parameter int MEDIUM_SLOTS = 64,
    parameter int SMALL_SLOTS  = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ssba_pkg::tok_t tok_in,
    output ssba_pkg::tok_t tok_out
);

    localparam int CB    = ssba_pkg::CELL_BITS;
    localparam int CW    = ssba_pkg::CELL_W;
    localparam int SW    = ssba_pkg::SLOT_W;
    localparam int IDX_W = ssba_pkg::CELL_IDX_W;

    localparam logic [CB-1:0] LARGE_MASK  = ssba_pkg::cell_mask(LARGE_SLOTS, CELL_IDX);
    localparam logic [CB-1:0] MEDIUM_MASK = ssba_pkg::cell_mask(MEDIUM_SLOTS, CELL_IDX);
    localparam logic [CB-1:0] SMALL_MASK  = ssba_pkg::cell_mask(SMALL_SLOTS, CELL_IDX);
    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);

    logic [CB-1:0]  large_reg, large_next;
    logic [CB-1:0]  medium_reg, medium_next;
    logic [CB-1:0]  small_reg, small_next;
    ssba_pkg::tok_t tok_reg, tok_next;

    logic [CB-1:0] sel_used;
    logic [CB-1:0] sel_mask;
    logic [CB-1:0] free_bits;
    logic [CB-1:0] low_bit;
    logic [CW-1:0] low_idx;
    logic [CB-1:0] set_bits;
    logic [CB-1:0] clr_bits;
    logic          ok;
    logic          do_alloc;
    logic          do_free;

    always_comb
    begin
        unique case (tok_in.pool)
            ssba_pkg::POOL_LARGE:
            begin
                sel_used = large_reg;
                sel_mask = LARGE_MASK;
            end
            ssba_pkg::POOL_MEDIUM:
            begin
                sel_used = medium_reg;
                sel_mask = MEDIUM_MASK;
            end
            ssba_pkg::POOL_SMALL:
            begin
                sel_used = small_reg;
                sel_mask = SMALL_MASK;
            end
            default:
            begin
                sel_used = '1;
                sel_mask = '0;
            end
        endcase
    end

    // The lowest free bit is isolated with a two's complement trick.
    assign free_bits = ~sel_used & sel_mask;
    assign low_bit   = free_bits & (~free_bits + CB'(1));

    always_comb
    begin
        low_idx = '0;
        for (int b = 0; b < CW; b++)
        begin
            for (int i = 0; i < CB; i++)
            begin
                if (low_bit[i] && (((i >> b) & 1) == 1))
                begin
                    low_idx[b] = 1'b1;
                end
            end
        end
    end

    assign ok       = tok_in.valid && (tok_in.status == ssba_pkg::ST_OK);
    assign do_alloc = ok && (tok_in.req_type == ssba_pkg::REQ_ALLOC) && !tok_in.found
                      && (|free_bits);
    assign do_free  = ok && (tok_in.req_type == ssba_pkg::REQ_FREE)
                      && (tok_in.slot[SW-1:CW] == MY_IDX);
    assign set_bits = do_alloc ? low_bit : '0;
    assign clr_bits = do_free ? (CB'(1) << tok_in.slot[CW-1:0]) : '0;

    always_comb
    begin
        large_next  = large_reg;
        medium_next = medium_reg;
        small_next  = small_reg;
        unique case (tok_in.pool)
            ssba_pkg::POOL_LARGE:  large_next  = (large_reg | set_bits) & ~clr_bits;
            ssba_pkg::POOL_MEDIUM: medium_next = (medium_reg | set_bits) & ~clr_bits;
            ssba_pkg::POOL_SMALL:  small_next  = (small_reg | set_bits) & ~clr_bits;
            default:               large_next  = large_reg;
        endcase

        tok_next = tok_in;
        if (do_alloc)
        begin
            tok_next.found = 1'b1;
            tok_next.slot  = {MY_IDX, low_idx};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            large_reg  <= '0;
            medium_reg <= '0;
            small_reg  <= '0;
            tok_reg    <= '0;
        end
        else
        begin
            large_reg  <= large_next;
            medium_reg <= medium_next;
            small_reg  <= small_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule
